/* rtl/circle_disc_span_generator_unit_macros.svh */
// Assertion macros shared by the circle and disc span generator RTL.
`ifndef CIRCLE_DISC_SPAN_GENERATOR_UNIT_MACROS_SVH
`define CIRCLE_DISC_SPAN_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CDSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CDSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cdsg_pkg.sv */
// Shared constants, types and rounding functions of the circle and disc span generator.
package cdsg_pkg;

  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned MAX_RADIUS = 31;
  localparam int unsigned HALF_LSB   = 1 << (FRAC_BITS - 1);

  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned RAD_IN_W   = 9;
  localparam int unsigned PIX_W      = 13;
  localparam int unsigned RAD_W      = 5;
  localparam int unsigned DY_W       = RAD_W + 1;
  localparam int unsigned SPAN_W     = 6;
  localparam int unsigned SQ_W       = 2 * RAD_W;
  localparam int unsigned ROOT_W     = RAD_W + 1;

  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 56;

  // Request into the shared square root unit.
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  // Response of the shared square root unit: root rounded half up.
  typedef struct packed {
    logic             done;
    logic [RAD_W-1:0] root;
  } sqrt_rsp_t;

  // Round a signed fixed-point coordinate half up to whole pixels.
  function automatic logic signed [PIX_W-1:0] round_coord(
    input logic signed [COORD_IN_W-1:0] v
  );
    logic signed [COORD_IN_W:0] s;
    logic signed [COORD_IN_W:0] sh;
    s  = $signed({v[COORD_IN_W-1], v}) + $signed((COORD_IN_W+1)'(HALF_LSB));
    sh = s >>> FRAC_BITS;
    return sh[PIX_W-1:0];
  endfunction

  // Round an unsigned fixed-point radius half up and saturate it.
  function automatic logic [RAD_W-1:0] round_radius(input logic [RAD_IN_W-1:0] raw);
    logic [RAD_IN_W:0] s;
    logic [RAD_IN_W:0] t;
    s = {1'b0, raw} + (RAD_IN_W+1)'(HALF_LSB);
    t = s >> FRAC_BITS;
    if (t > (RAD_IN_W+1)'(MAX_RADIUS)) begin
      t = (RAD_IN_W+1)'(MAX_RADIUS);
    end
    return t[RAD_W-1:0];
  endfunction

endpackage

/* rtl/circle_disc_span_generator_unit.sv */
// Top level of the circle and disc span generator: command intake, row sequencer, result register.
//
//   Channel   Direction  Bus        Contents (lowest bit first)
//   s_axis    in         tdata      center_x[15:0], center_y[31:16], radius[40:32], zero fill
//   s_axis    in         tuser      outline_mode
//   m_axis    out        tdata      row_y, left_x, left_width, right_x, right_width, zero fill
//   m_axis    out        tlast      last_row
//
// A request is latched as it is taken; each disc row, and the top and bottom outline rows,
// need one square root, and the other outline rows need two, because the
// half-widths come one after the other from a single six-step square root unit.
// A shape of rounded radius r emits 2r+1 rows; a radius that rounds to zero emits nothing.
// Reset (asynchronous, active low) returns the sequencer to idle and empties the result register.
// A stalled result register holds the sequencer in its emit step; the next request is taken
// while the final row of the previous shape still waits in the result register.
`include "circle_disc_span_generator_unit_macros.svh"

module circle_disc_span_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // center_x [15:0], center_y [31:16], radius [40:32], zeros [47:41]
  input  logic [cdsg_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // outline_mode [0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // row_y [12:0], left_x [25:13], left_width [31:26], right_x [44:32],
  // right_width [50:45], zeros [55:51]
  output logic [cdsg_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // last_row
  output logic                           m_axis_tlast
);
  import cdsg_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_ROW  = 3'd1;  // launch the outer half-width root
  localparam logic [2:0] ST_SQO  = 3'd2;  // outer root in progress
  localparam logic [2:0] ST_SQI  = 3'd3;  // inner root in progress (outline only)
  localparam logic [2:0] ST_EMIT = 3'd4;  // hand the row to the result register

  localparam int unsigned PAD_W = M_TDATA_W - (3 * PIX_W + 2 * SPAN_W);

  logic [2:0]              state_q, state_d;

  // Latched shape.
  logic signed [PIX_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]        r_q;
  logic                    mode_q;
  logic [SQ_W-1:0]         r2_q;

  // Row position and its square, advanced incrementally.
  logic signed [DY_W-1:0]  dy_q;
  logic [SQ_W-1:0]         dy2_q;

  // Half-widths of the outer and inner circles for the current row.
  logic [RAD_W-1:0]        ho_q, hi_q;

  // Result register.
  logic                    m_valid_q;
  logic [M_TDATA_W-1:0]    m_data_q;
  logic                    m_last_q;

  // Incoming request decode.
  logic                    s_fire;
  logic signed [PIX_W-1:0] in_cx, in_cy;
  logic [RAD_W-1:0]        in_r;
  logic [SQ_W-1:0]         in_r2;

  // Sequencer helpers.
  logic signed [DY_W-1:0]  r_s;
  logic                    row_last;
  logic                    inner_ok;
  logic                    full_row;
  logic [SQ_W-1:0]         ri2;
  logic signed [SQ_W:0]    dy_step;
  logic signed [SQ_W:0]    dy2_sum;
  logic                    emit_fire;

  // Row fields.
  logic signed [PIX_W-1:0] row_y, left_x, right_x;
  logic [SPAN_W-1:0]       left_w, right_w, ring_w;
  logic signed [PIX_W-1:0] ho_ext, hi_ext;

  sqrt_req_t               sqrt_req;
  sqrt_rsp_t               sqrt_rsp;

  cdsg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // The sequencer only takes a request between shapes.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_cx = round_coord(s_axis_tdata[COORD_IN_W-1:0]);
  assign in_cy = round_coord(s_axis_tdata[2*COORD_IN_W-1:COORD_IN_W]);
  assign in_r  = round_radius(s_axis_tdata[2*COORD_IN_W+RAD_IN_W-1:2*COORD_IN_W]);
  assign in_r2 = in_r * in_r;

  // The inner circle of radius r-1 reaches every row except the top and bottom ones.
  // Its squared radius follows from r*r without a second multiply.
  assign r_s      = $signed({1'b0, r_q});
  assign row_last = (dy_q == r_s);
  assign inner_ok = (dy_q != r_s) && (dy_q != -r_s);
  assign full_row = !mode_q || !inner_ok;
  assign ri2      = r2_q - {r_q, 1'b0} + SQ_W'(1);

  // Moving down one row adds 2*dy+1 to dy squared.
  assign dy_step = {{(SQ_W - DY_W){dy_q[DY_W-1]}}, dy_q, 1'b1};
  assign dy2_sum = $signed({1'b0, dy2_q}) + dy_step;

  // The root unit is started for the outer circle in the row step, and for the
  // inner circle right as the outer root comes back.
  always_comb begin
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = r2_q - dy2_q;
    case (state_q)
      ST_ROW: begin
        sqrt_req.start = 1'b1;
      end
      ST_SQO: begin
        sqrt_req.start    = sqrt_rsp.done && mode_q && inner_ok;
        sqrt_req.radicand = ri2 - dy2_q;
      end
      default: begin
        sqrt_req.start = 1'b0;
      end
    endcase
  end

  // Row spans. An outline row inside the inner circle splits into the two rings
  // left and right of it; every other row is a single span of 2h+1 pixels.
  assign ho_ext  = $signed({{(PIX_W - RAD_W){1'b0}}, ho_q});
  assign hi_ext  = $signed({{(PIX_W - RAD_W){1'b0}}, hi_q});
  assign ring_w  = SPAN_W'(ho_q - hi_q);
  assign row_y   = cy_q + {{(PIX_W - DY_W){dy_q[DY_W-1]}}, dy_q};
  assign left_x  = cx_q - ho_ext;
  assign left_w  = full_row ? {ho_q, 1'b1} : ring_w;
  assign right_x = full_row ? '0 : (cx_q + hi_ext + PIX_W'(1));
  assign right_w = full_row ? '0 : ring_w;

  // A row leaves once the result register is empty or being drained this cycle.
  assign emit_fire = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_r != '0)) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        state_d = ST_SQO;
      end
      ST_SQO: begin
        if (sqrt_rsp.done) begin
          state_d = (mode_q && inner_ok) ? ST_SQI : ST_EMIT;
        end
      end
      ST_SQI: begin
        if (sqrt_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = row_last ? ST_IDLE : ST_ROW;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Shape, row and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cx_q   <= in_cx;
      cy_q   <= in_cy;
      r_q    <= in_r;
      r2_q   <= in_r2;
      mode_q <= s_axis_tuser;
      dy_q   <= -$signed({1'b0, in_r});
      dy2_q  <= in_r2;
    end else if (emit_fire && !row_last) begin
      dy_q  <= dy_q + DY_W'(1);
      dy2_q <= dy2_sum[SQ_W-1:0];
    end
    if ((state_q == ST_SQO) && sqrt_rsp.done) begin
      ho_q <= sqrt_rsp.root;
    end
    if ((state_q == ST_SQI) && sqrt_rsp.done) begin
      hi_q <= sqrt_rsp.root;
    end
    if (emit_fire) begin
      m_data_q <= {{PAD_W{1'b0}}, right_w, right_x, left_w, left_x, row_y};
      m_last_q <= row_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // The root unit answers only while the sequencer waits for it.
  `CDSG_ASSERT_IMPL(a_root_when_waiting, clk_i, rst_ni, sqrt_rsp.done, (state_q == ST_SQO) || (state_q == ST_SQI), "square root finished outside a wait step")
  // A shape in progress always has a nonzero radius.
  `CDSG_ASSERT_IMPL(a_radius_nonzero, clk_i, rst_ni, state_q != ST_IDLE, r_q != '0, "shape running with zero radius")
  // The row offset never leaves the circle, so the outer radicand stays nonnegative.
  `CDSG_ASSERT_IMPL(a_row_in_circle, clk_i, rst_ni, state_q != ST_IDLE, dy2_q <= r2_q, "row offset outside the circle")
  // Handing over the bottom row ends the shape.
  `CDSG_ASSERT_NEXT(a_last_row_ends, clk_i, rst_ni, emit_fire && row_last, (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast, "bottom row did not end the shape")

endmodule

/* rtl/cdsg_isqrt.sv */
// Bit-serial square root unit, one root bit per cycle, result rounded half up.
module cdsg_isqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdsg_pkg::sqrt_req_t   req_i,
  output cdsg_pkg::sqrt_rsp_t   rsp_o
);
  import cdsg_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROOT_W);

  logic                busy_q;
  logic                done_q;
  logic [IDX_W-1:0]    idx_q;
  logic [SQ_W+1:0]     x_q;
  logic [ROOT_W-1:0]   q_q;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic                fits;
  logic [ROOT_W:0]     q_inc;

  // The root of 4n, halved after adding one, is the root of n rounded half up.
  assign trial    = q_q | (ROOT_W'(1) << idx_q);
  assign trial_sq = trial * trial;
  assign fits     = trial_sq <= x_q;
  assign q_inc    = {1'b0, q_q} + (ROOT_W+1)'(1);

  assign rsp_o.done = done_q;
  assign rsp_o.root = q_inc[RAD_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      idx_q  <= IDX_W'(ROOT_W - 1);
    end else if (busy_q) begin
      if (idx_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        idx_q  <= idx_q - IDX_W'(1);
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= {req_i.radicand, 2'b00};
      q_q <= '0;
    end else if (busy_q && fits) begin
      q_q <= trial;
    end
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the circle and disc span generator.
`timescale 1ns / 100ps

module testbench;
  import cdsg_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 7;
  localparam int RANDOM_SHAPES   = 360;
  localparam int MAX_REPORTS     = 10;
  // The longest quiet stretch of a correct run is the long receiver hold-off
  // plus one outline row, so this leaves plenty of margin.
  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 700;
  // Covers the latch of a request and the slowest row, with margin.
  localparam int SETTLE_CYCLES   = 40;

  typedef enum logic {
    SHAPE_DISC    = 1'b0,
    SHAPE_OUTLINE = 1'b1
  } shape_mode_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_ASKED,
    HOLD_ON
  } hold_state_e;

  typedef struct packed {
    logic signed [PIX_W-1:0] row_y;
    logic signed [PIX_W-1:0] left_x;
    logic [SPAN_W-1:0]       left_w;
    logic signed [PIX_W-1:0] right_x;
    logic [SPAN_W-1:0]       right_w;
    logic                    last;
  } span_row_t;

  // A known_count of -1 leaves the rows to the predictor; otherwise the rows
  // are read from KNOWN_ROWS starting at known_at.
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [8:0]  rad;
    shape_mode_e mode;
    int          known_at;
    int          known_count;
  } shape_case_t;

  // Rows that follow directly from the one-pixel shapes of the directed table.
  localparam span_row_t KNOWN_ROWS [6] = '{
    // Unit disc at the origin.
    '{-13'sd1, 13'sd0, 6'd1, 13'sd0, 6'd0, 1'b0},
    '{13'sd0, -13'sd1, 6'd3, 13'sd0, 6'd0, 1'b0},
    '{13'sd1, 13'sd0, 6'd1, 13'sd0, 6'd0, 1'b1},
    // Unit outline at the far right, top corner of the coordinate range.
    '{-13'sd2049, 13'sd2048, 6'd1, 13'sd0, 6'd0, 1'b0},
    '{-13'sd2048, 13'sd2047, 6'd1, 13'sd2049, 6'd1, 1'b0},
    '{-13'sd2047, 13'sd2048, 6'd1, 13'sd0, 6'd0, 1'b1}
  };

  localparam int NUM_DIRECTED = 16;
  localparam shape_case_t DIRECTED [NUM_DIRECTED] = '{
    '{16'h0000, 16'h0000, 9'd16,  SHAPE_DISC,    0, 3},
    '{16'h7FFF, 16'h8000, 9'd8,   SHAPE_OUTLINE, 3, 3},
    // Radius just below half a pixel, then zero at the opposite extremes.
    '{16'h0000, 16'h0000, 9'd7,   SHAPE_DISC,    0, 0},
    '{16'h8000, 16'h7FFF, 9'd0,   SHAPE_OUTLINE, 0, 0},
    '{16'h0000, 16'h0000, 9'd503, SHAPE_DISC,    0, -1},
    '{16'h0000, 16'h0000, 9'd503, SHAPE_OUTLINE, 0, -1},
    // Radius beyond the largest shape saturates.
    '{16'h8000, 16'h8000, 9'd511, SHAPE_DISC,    0, -1},
    '{16'h7FFF, 16'h7FFF, 9'd511, SHAPE_OUTLINE, 0, -1},
    // Half-pixel rounding of the centre and the radius.
    '{16'h0008, 16'hFFF8, 9'd24,  SHAPE_DISC,    0, -1},
    '{16'hFFF7, 16'h0007, 9'd23,  SHAPE_OUTLINE, 0, -1},
    '{16'h1234, 16'hABCD, 9'd40,  SHAPE_OUTLINE, 0, -1},
    '{16'hFFFF, 16'h0001, 9'd80,  SHAPE_OUTLINE, 0, -1},
    '{16'h5555, 16'hAAAA, 9'd160, SHAPE_DISC,    0, -1},
    '{16'hAAAA, 16'h5555, 9'd496, SHAPE_OUTLINE, 0, -1},
    '{16'h0000, 16'h0000, 9'd487, SHAPE_OUTLINE, 0, -1},
    '{16'h0000, 16'h0000, 9'd488, SHAPE_DISC,    0, -1}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  span_row_t   expected_rows[$];
  int          failures     = 0;
  int          quiet_cycles = 0;
  bit          steady_phase = 1'b0;
  hold_state_e hold_state   = HOLD_NONE;

  // Predictor state: the command latched last.
  logic signed [PIX_W-1:0] held_cx     = '0;
  logic signed [PIX_W-1:0] held_cy     = '0;
  logic [RAD_W-1:0]        held_radius = '0;
  shape_mode_e             held_mode   = SHAPE_DISC;

  always #HALF_PERIOD clk_i = ~clk_i;

  circle_disc_span_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Fixed-point coordinate to whole pixels, half rounded up (floor of v + 1/2).
  function automatic logic signed [PIX_W-1:0] pixel_coord(input logic [15:0] raw);
    int biased;
    biased = int'($signed(raw)) + int'(HALF_LSB);
    return PIX_W'(biased >>> FRAC_BITS);
  endfunction

  function automatic logic [RAD_W-1:0] pixel_radius(input logic [8:0] raw);
    int unsigned whole;
    whole = (int'(raw) + HALF_LSB) >> FRAC_BITS;
    if (whole > MAX_RADIUS) whole = MAX_RADIUS;
    return RAD_W'(whole);
  endfunction

  // Square root rounded half up; an exact half cannot occur for integers.
  function automatic int rounded_root(input int n);
    int k;
    k = 0;
    while ((k + 1) * (k + 1) <= n) k++;
    if (n > k * k + k) k++;
    return k;
  endfunction

  // Half-width of a circle of radius r at row offset dy, -1 outside the circle.
  function automatic int half_span(input int r, input int dy);
    if (r < 0 || dy > r || dy < -r) return -1;
    return rounded_root(r * r - dy * dy);
  endfunction

  // Latches one shape command and queues every row that it draws.
  function automatic void predict_rows(input logic [15:0] cx_raw, input logic [15:0] cy_raw,
                                       input logic [8:0] rad_raw, input shape_mode_e mode);
    int        r;
    int        dy;
    int        outer;
    int        inner;
    int        cx;
    int        cy;
    int        lx;
    int        lw;
    int        rx;
    int        rw;
    span_row_t row;
    held_cx     = pixel_coord(cx_raw);
    held_cy     = pixel_coord(cy_raw);
    held_radius = pixel_radius(rad_raw);
    held_mode   = mode;
    r  = int'(held_radius);
    cx = int'(held_cx);
    cy = int'(held_cy);
    if (r < 1) return;
    for (dy = -r; dy <= r; dy++) begin
      outer = half_span(r, dy);
      lx    = cx - outer;
      lw    = 2 * outer + 1;
      rx    = 0;
      rw    = 0;
      // An outline row splits into two spans wherever the inner circle
      // reaches it; both may come out empty where the half-widths match.
      if (held_mode == SHAPE_OUTLINE) begin
        inner = half_span(r - 1, dy);
        if (inner >= 0) begin
          lw = outer - inner;
          rx = cx + inner + 1;
          rw = outer - inner;
        end
      end
      row.row_y   = PIX_W'(cy + dy);
      row.left_x  = PIX_W'(lx);
      row.left_w  = SPAN_W'(lw);
      row.right_x = PIX_W'(rx);
      row.right_w = SPAN_W'(rw);
      row.last    = (dy == r);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic string describe_row(input span_row_t row);
    return $sformatf("y=%0d lx=%0d lw=%0d rx=%0d rw=%0d last=%0b", row.row_y, row.left_x,
                     row.left_w, row.right_x, row.right_w, row.last);
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  // Offers one shape request, queues its rows once it is taken, then may idle for a random gap.
  task automatic offer_shape(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [8:0] rad, input shape_mode_e mode,
                             input int known_at, input int known_count);
    int gap;
    int k;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, rad, cy, cx};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    if (known_count < 0) begin
      predict_rows(cx, cy, rad, mode);
    end else begin
      for (k = 0; k < known_count; k++) expected_rows.push_back(KNOWN_ROWS[known_at + k]);
    end
    // Keep offering without gaps in the steady phase and while the receiver holds off, so the block fills up.
    gap = (steady_phase || hold_state != HOLD_NONE) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender pause: nothing is offered until every queued row has come out.
  // The do-while form always waits on the clock, so the next offer lands on a later edge.
  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_rows.size() != 0);
  endtask

  initial begin : stimulus
    int          i;
    int          pick;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [8:0]  rad;
    shape_mode_e mode;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < NUM_DIRECTED; i++) begin
      offer_shape(DIRECTED[i].cx, DIRECTED[i].cy, DIRECTED[i].rad, DIRECTED[i].mode,
                  DIRECTED[i].known_at, DIRECTED[i].known_count);
    end
    await_drain();
    for (i = 0; i < RANDOM_SHAPES; i++) begin
      steady_phase = (i >= 60 && i < 110);
      if (i == 150) hold_state = HOLD_ASKED;
      if (i == 250) await_drain();
      // Small shapes dominate so that the run stays short; the full radius
      // range, including saturation, still shows up regularly.
      pick = int'($urandom_range(0, 99));
      if (pick < 5) rad = 9'($urandom_range(0, 7));
      else if (pick < 75) rad = 9'($urandom_range(8, 136));
      else rad = 9'($urandom_range(0, 511));
      if ($urandom_range(0, 7) == 0) cx = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      else cx = 16'($urandom);
      if ($urandom_range(0, 7) == 0) cy = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      else cy = 16'($urandom);
      mode = shape_mode_e'($urandom_range(0, 1));
      offer_shape(cx, cy, rad, mode, 0, -1);
    end
    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, a stall-free stretch, and one long hold-off.
  initial begin : receiver
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_state == HOLD_ASKED) begin
        hold_state = HOLD_ON;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_state = HOLD_NONE;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      stall = steady_phase ? 0 : pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Each row that leaves the block must match the oldest queued row.
  always @(posedge clk_i) begin : row_check
    span_row_t got;
    span_row_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row_y   = m_axis_tdata[12:0];
      got.left_x  = m_axis_tdata[25:13];
      got.left_w  = m_axis_tdata[31:26];
      got.right_x = m_axis_tdata[44:32];
      got.right_w = m_axis_tdata[50:45];
      got.last    = m_axis_tlast;
      if (expected_rows.size() == 0) begin
        note_failure($sformatf("unexpected row: %s", describe_row(got)));
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          note_failure($sformatf("row mismatch: expected %s, got %s", describe_row(want),
                                 describe_row(got)));
        end
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
